// File: rtl/core/sjb_pkg.sv
// Shared types, constants and helper functions of the sequence jitter buffer.
// Used by the interfaces, the controller, the datapath, the top level and the checker.
package sjb_pkg;

  localparam int unsigned ENTRIES  = 64;
  localparam int unsigned TAG_BITS = 16;
  localparam int unsigned SEQ_W    = 64;
  localparam int unsigned CFG_W    = 7;
  localparam int unsigned IDX_W    = $clog2(ENTRIES);
  localparam int unsigned FILL_W   = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W    = (FILL_W > CFG_W) ? FILL_W : CFG_W;

  typedef enum logic [1:0] {
    REQ_PUSH  = 2'd0,
    REQ_POP   = 2'd1,
    REQ_FLUSH = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    STS_ACCEPTED = 3'd0,
    STS_LATE     = 3'd1,
    STS_DUP      = 3'd2,
    STS_OVERFLOW = 3'd3,
    STS_NONE     = 3'd4,
    STS_PACKET   = 3'd5,
    STS_CONCEAL  = 3'd6,
    STS_FLUSHED  = 3'd7
  } status_e;

  typedef enum logic {
    CFG_TARGET_FILL = 1'b0,
    CFG_MAX_FILL    = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] seq_in;
    logic [15:0] tag_in;
    logic        deadline_over;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] seq_out;
    logic [15:0] tag_out;
    logic [6:0]  fill_level;
    logic [31:0] accepted_total;
    logic [31:0] late_total;
    logic [31:0] duplicate_total;
    logic [31:0] overflow_total;
    logic [31:0] conceal_total;
  } rsp_t;

  typedef struct packed {
    logic capture;
    logic scan;
    logic exec;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic needs_scan;
    logic scan_last;
    logic out_free;
  } sts_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

endpackage

// File: rtl/core/sjb_if.sv
// Request and response channel interfaces of the sequence jitter buffer.
// Depends on sjb_pkg for the payload structs.
interface sjb_req_if import sjb_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sjb_rsp_if import sjb_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/sjb_ctrl.sv
// Controller state machine of the sequence jitter buffer.
// Depends on sjb_pkg; drives the datapath through cmd_t and reads sts_t.
module sjb_ctrl import sjb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_DRAIN = 5'b00100,
    S_EXEC  = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = sts_i.needs_scan ? S_SCAN : S_EXEC;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/core/sjb_dp.sv
// Datapath of the sequence jitter buffer: entry memory, scan, state update, result register.
// Depends on sjb_pkg; commanded by sjb_ctrl.
module sjb_dp import sjb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  req_t             req_i,
  input  cmd_t             cmd_i,
  output sts_t             sts_o,
  output logic             rsp_valid_o,
  input  logic             rsp_ready_i,
  output rsp_t             rsp_o
);

  logic [CFG_W-1:0]          target_q, maxf_q;
  req_e                      req_q;
  logic [SEQ_W-1:0]          seq_q;
  logic [TAG_BITS-1:0]       tag_q;
  logic                      dl_q;
  logic [IDX_W-1:0]          scan_idx_q, rd_idx_q;
  logic                      rd_vld_q;
  logic [SEQ_W+TAG_BITS-1:0] mem [ENTRIES];
  logic [SEQ_W+TAG_BITS-1:0] rd_q;
  logic [ENTRIES-1:0]        valid_q, valid_d;
  logic                      hit_fnd_q, min_fnd_q, free_fnd_q;
  logic [IDX_W-1:0]          hit_idx_q, min_idx_q, free_idx_q;
  logic [TAG_BITS-1:0]       hit_tag_q, min_tag_q;
  logic [SEQ_W-1:0]          min_seq_q;
  logic                      locked_q, locked_d;
  logic [SEQ_W-1:0]          exp_q, exp_d;
  logic [FILL_W-1:0]         fill_q, fill_d;
  logic [31:0]               acc_q, late_q, dup_q, ovf_q, conc_q;
  logic [31:0]               acc_d, late_d, dup_d, ovf_d, conc_d;
  status_e                   res_st_q, res_st_d;
  logic [SEQ_W-1:0]          res_seq_q, res_seq_d;
  logic [TAG_BITS-1:0]       res_tag_q, res_tag_d;
  logic                      out_valid_q;
  rsp_t                      out_q;

  logic [SEQ_W-1:0]    rd_seq, key, exp_eff;
  logic [TAG_BITS-1:0] rd_tag, pop_tag;
  logic                rd_live, pop_go, pop_hit, mem_we;
  logic [IDX_W-1:0]    pop_idx;

  assign rd_seq  = rd_q[SEQ_W+TAG_BITS-1:TAG_BITS];
  assign rd_tag  = rd_q[TAG_BITS-1:0];
  assign rd_live = rd_vld_q && valid_q[rd_idx_q];
  assign key     = (req_q == REQ_POP) ? exp_q : seq_q;

  assign sts_o.needs_scan = (req_i.req_type == REQ_PUSH) || (req_i.req_type == REQ_POP);
  assign sts_o.scan_last  = (scan_idx_q == IDX_W'(ENTRIES - 1));
  assign sts_o.out_free   = !out_valid_q || rsp_ready_i;

  assign pop_go  = locked_q || ((fill_q != '0) && (CMP_W'(fill_q) >= CMP_W'(target_q)));
  assign exp_eff = locked_q ? exp_q : min_seq_q;
  assign pop_hit = locked_q ? hit_fnd_q : 1'b1;
  assign pop_idx = locked_q ? hit_idx_q : min_idx_q;
  assign pop_tag = locked_q ? hit_tag_q : min_tag_q;

  always_comb begin
    valid_d   = valid_q;
    locked_d  = locked_q;
    exp_d     = exp_q;
    fill_d    = fill_q;
    acc_d     = acc_q;
    late_d    = late_q;
    dup_d     = dup_q;
    ovf_d     = ovf_q;
    conc_d    = conc_q;
    res_st_d  = STS_NONE;
    res_seq_d = '0;
    res_tag_d = '0;
    mem_we    = 1'b0;
    if (cmd_i.exec) begin
      case (req_q)
        REQ_PUSH: begin
          if (locked_q && (seq_q < exp_q)) begin
            res_st_d = STS_LATE;
            late_d   = sat_inc(late_q);
          end else if (hit_fnd_q) begin
            res_st_d = STS_DUP;
            dup_d    = sat_inc(dup_q);
          end else if ((CMP_W'(fill_q) >= CMP_W'(maxf_q)) ||
                       (fill_q == FILL_W'(ENTRIES)) || !free_fnd_q) begin
            res_st_d = STS_OVERFLOW;
            ovf_d    = sat_inc(ovf_q);
          end else begin
            res_st_d            = STS_ACCEPTED;
            acc_d               = sat_inc(acc_q);
            mem_we              = 1'b1;
            valid_d[free_idx_q] = 1'b1;
            fill_d              = fill_q + FILL_W'(1);
          end
        end
        REQ_POP: begin
          if (pop_go) begin
            locked_d = 1'b1;
            exp_d    = exp_eff;
            if (pop_hit) begin
              res_st_d         = STS_PACKET;
              res_seq_d        = exp_eff;
              res_tag_d        = pop_tag;
              valid_d[pop_idx] = 1'b0;
              fill_d           = fill_q - FILL_W'(1);
              exp_d            = exp_eff + SEQ_W'(1);
            end else if (dl_q || (min_fnd_q && (min_seq_q > exp_eff))) begin
              res_st_d  = STS_CONCEAL;
              res_seq_d = exp_eff;
              exp_d     = exp_eff + SEQ_W'(1);
              conc_d    = sat_inc(conc_q);
            end
          end
        end
        REQ_FLUSH: begin
          res_st_d = STS_FLUSHED;
          valid_d  = '0;
          fill_d   = '0;
          locked_d = 1'b0;
          exp_d    = '0;
        end
        default: begin
          res_st_d = STS_NONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[free_idx_q] <= {seq_q, tag_q};
    end
    if (cmd_i.scan) begin
      rd_q <= mem[scan_idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_e'(req_i.req_type);
      seq_q <= req_i.seq_in;
      tag_q <= TAG_BITS'(req_i.tag_in);
      dl_q  <= req_i.deadline_over;
    end
    rd_idx_q <= scan_idx_q;
    if (rd_live && !hit_fnd_q && (rd_seq == key)) begin
      hit_idx_q <= rd_idx_q;
      hit_tag_q <= rd_tag;
    end
    if (rd_live && (!min_fnd_q || (rd_seq < min_seq_q))) begin
      min_seq_q <= rd_seq;
      min_idx_q <= rd_idx_q;
      min_tag_q <= rd_tag;
    end
    if (rd_vld_q && !valid_q[rd_idx_q] && !free_fnd_q) begin
      free_idx_q <= rd_idx_q;
    end
    if (cmd_i.exec) begin
      res_st_q  <= res_st_d;
      res_seq_q <= res_seq_d;
      res_tag_q <= res_tag_d;
    end
    if (cmd_i.load_out) begin
      out_q.status          <= res_st_q;
      out_q.seq_out         <= res_seq_q;
      out_q.tag_out         <= 16'(res_tag_q);
      out_q.fill_level      <= 7'(fill_q);
      out_q.accepted_total  <= acc_q;
      out_q.late_total      <= late_q;
      out_q.duplicate_total <= dup_q;
      out_q.overflow_total  <= ovf_q;
      out_q.conceal_total   <= conc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q    <= CFG_W'(4);
      maxf_q      <= CFG_W'(16);
      scan_idx_q  <= '0;
      rd_vld_q    <= 1'b0;
      hit_fnd_q   <= 1'b0;
      min_fnd_q   <= 1'b0;
      free_fnd_q  <= 1'b0;
      valid_q     <= '0;
      locked_q    <= 1'b0;
      exp_q       <= '0;
      fill_q      <= '0;
      acc_q       <= '0;
      late_q      <= '0;
      dup_q       <= '0;
      ovf_q       <= '0;
      conc_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_TARGET_FILL) begin
          target_q <= cfg_wdata_i;
        end else begin
          maxf_q <= cfg_wdata_i;
        end
      end
      rd_vld_q <= cmd_i.scan;
      if (cmd_i.capture) begin
        scan_idx_q <= '0;
        hit_fnd_q  <= 1'b0;
        min_fnd_q  <= 1'b0;
        free_fnd_q <= 1'b0;
      end else begin
        if (cmd_i.scan) begin
          scan_idx_q <= scan_idx_q + IDX_W'(1);
        end
        if (rd_live && (rd_seq == key)) begin
          hit_fnd_q <= 1'b1;
        end
        if (rd_live) begin
          min_fnd_q <= 1'b1;
        end
        if (rd_vld_q && !valid_q[rd_idx_q]) begin
          free_fnd_q <= 1'b1;
        end
      end
      valid_q  <= valid_d;
      locked_q <= locked_d;
      exp_q    <= exp_d;
      fill_q   <= fill_d;
      acc_q    <= acc_d;
      late_q   <= late_d;
      dup_q    <= dup_d;
      ovf_q    <= ovf_d;
      conc_q   <= conc_d;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign rsp_valid_o = out_valid_q;
  assign rsp_o       = out_q;

endmodule

// File: rtl/core/sequence_jitter_buffer.sv
// Top level of the sequence jitter buffer: controller plus datapath.
// Depends on sjb_pkg, sjb_if, sjb_ctrl and sjb_dp.
//
//   Port      Dir  Kind         Beat
//   req_i     in   valid/ready  one push, pop or flush request
//   rsp_o     out  valid/ready  one result per request
//   cfg_*_i   in   write only   target_fill (index 0), max_fill (index 1)
//
// A push or pop sweeps all ENTRIES stored entries one per cycle through the
// entry memory read port, then passes S_DRAIN, S_EXEC, S_DONE; a flush or an unused
// request skips the sweep. Reset clears the valid bits at once, so no clearing
// pass follows it. A new request is accepted while the previous result waits
// in the output register; a stalled output holds the block before its next result.
module sequence_jitter_buffer import sjb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  sjb_req_if.sink          req_i,
  sjb_rsp_if.source        rsp_o
);

  cmd_t cmd;
  sts_t sts;

  sjb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sjb_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i.data),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .rsp_o       (rsp_o.data)
  );

endmodule

// File: rtl/core/sjb_chk.sv
// Port-level checker of the sequence jitter buffer response channel and its bind.
// Depends on sjb_pkg and attaches to sequence_jitter_buffer.
module sjb_chk import sjb_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic rsp_valid_i,
  input logic rsp_ready_i,
  input rsp_t rsp_data_i
);

  a_tag_only_packet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_data_i.status != STS_PACKET) |-> rsp_data_i.tag_out == '0)
    else $error("tag_out is set on a result that is not a packet");

  a_seq_only_play: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_data_i.status != STS_PACKET) && (rsp_data_i.status != STS_CONCEAL)
    |-> rsp_data_i.seq_out == '0)
    else $error("seq_out is set on a result that plays nothing");

  a_flush_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_data_i.status == STS_FLUSHED) |-> rsp_data_i.fill_level == '0)
    else $error("fill level is not zero after a flush");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_data_i))
    else $error("stalled result beat changed");

endmodule

bind sequence_jitter_buffer sjb_chk u_sjb_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_data_i  (rsp_o.data)
);
